@@ rtl/skt_pkg.sv @@
// Shared types and constants for the sorted key table leaf.
package skt_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] MAX_RESET = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_SPLIT  = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE  = 3'd0,
		ST_MISS  = 3'd1,
		ST_DUP   = 3'd2,
		ST_FULL  = 3'd3,
		ST_SPLIT = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [63:0] key;
		logic signed [31:0] page;
		logic signed [31:0] slot;
	} entry_t;

	typedef struct packed {
		logic          re;
		logic [AW-1:0] raddr;
		logic          we;
		logic [AW-1:0] waddr;
		entry_t        wdata;
	} mem_req_t;

	typedef struct packed {
		status_t          status;
		entry_t           ent;
		logic [CNT_W-1:0] count;
		logic             last;
	} result_t;

endpackage

@@ rtl/skt_mem.sv @@
// Entry memory: one write port, one read port, registered read data.
module skt_mem
	import skt_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rdata
);

	entry_t ram_q [CAPACITY];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			ram_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= ram_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/skt_ctrl.sv @@
// Sequencer for search, shift, split and clear, with the output register.
module skt_ctrl
	import skt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic signed [63:0]      search_key,
	input  logic signed [31:0]      entry_page,
	input  logic signed [31:0]      entry_slot,
	input  logic [CNT_W-1:0]        max_entries,
	output logic                    out_valid,
	input  logic                    out_ready,
	output result_t                 res,
	output mem_req_t                mem_req,
	input  entry_t                  mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT,
		S_SPLIT
	} state_t;

	state_t           state_q;
	action_t          act_q;
	entry_t           new_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] src_q;
	logic [CNT_W-1:0] wr_q;
	logic             pend_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] size_q;
	logic             ovalid_q;
	result_t          res_q;

	logic             can_emit;
	logic             emit_now;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] idx_nx;
	logic [CNT_W-1:0] src_m1;
	logic             split_last;
	logic             is_full;
	entry_t           zero_ent;

	assign can_emit   = !ovalid_q || out_ready;
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CNT_W:1];
	assign idx_nx     = idx_q + CNT_W'(1);
	assign src_m1     = src_q - CNT_W'(1);
	assign split_last = (idx_nx == size_q);
	assign is_full    = (count_q >= max_entries) || (count_q >= CNT_W'(CAPACITY));
	assign zero_ent   = '0;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign res       = res_q;

	// High in the states and cases that load a result once the output register is free.
	always_comb begin
		emit_now = 1'b0;
		case (state_q)
			S_DISPATCH: begin
				emit_now = (act_q == ACT_CLEAR) || (act_q == ACT_SPLIT && count_q == '0)
					|| (act_q == ACT_INSERT && is_full);
			end
			S_SRCH_RD: begin
				emit_now = !(lo_q < hi_q) && (act_q != ACT_INSERT);
			end
			S_SRCH_CMP: begin
				emit_now = (mem_rdata.key == new_q.key);
			end
			S_SHIFT: begin
				emit_now = !pend_q && (src_q <= pos_q);
			end
			S_SPLIT: begin
				emit_now = 1'b1;
			end
			default: begin
				emit_now = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_req       = '0;
		mem_req.wdata = new_q;
		case (state_q)
			S_DISPATCH: begin
				if (act_q == ACT_SPLIT && count_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = AW'(count_q >> 1);
				end
			end
			S_SRCH_RD: begin
				if (lo_q < hi_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = mid[AW-1:0];
				end
			end
			S_SHIFT: begin
				if (src_q > pos_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = src_m1[AW-1:0];
				end
				if (pend_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = wr_q[AW-1:0];
					mem_req.wdata = mem_rdata;
				end else if (src_q <= pos_q && can_emit) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_q[AW-1:0];
				end
			end
			S_SPLIT: begin
				if (can_emit && !split_last) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx_nx[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			act_q    <= ACT_LOOKUP;
			new_q    <= '0;
			count_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			pos_q    <= '0;
			src_q    <= '0;
			wr_q     <= '0;
			pend_q   <= 1'b0;
			idx_q    <= '0;
			size_q   <= '0;
			ovalid_q <= 1'b0;
			res_q    <= '0;
		end else begin
			if (out_ready && !(can_emit && emit_now)) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q      <= action_t'(action);
						new_q.key  <= search_key;
						new_q.page <= entry_page;
						new_q.slot <= entry_slot;
						state_q    <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (act_q)
						ACT_CLEAR: begin
							if (can_emit) begin
								count_q  <= '0;
								ovalid_q <= 1'b1;
								res_q    <= '{ST_DONE, zero_ent, '0, 1'b1};
								state_q  <= S_IDLE;
							end
						end
						ACT_SPLIT: begin
							if (count_q == '0) begin
								if (can_emit) begin
									ovalid_q <= 1'b1;
									res_q    <= '{ST_MISS, zero_ent, '0, 1'b1};
									state_q  <= S_IDLE;
								end
							end else begin
								size_q  <= count_q;
								idx_q   <= count_q >> 1;
								count_q <= count_q >> 1;
								state_q <= S_SPLIT;
							end
						end
						ACT_INSERT: begin
							if (is_full) begin
								if (can_emit) begin
									ovalid_q <= 1'b1;
									res_q    <= '{ST_FULL, zero_ent, count_q, 1'b1};
									state_q  <= S_IDLE;
								end
							end else begin
								lo_q    <= '0;
								hi_q    <= count_q;
								state_q <= S_SRCH_RD;
							end
						end
						default: begin
							lo_q    <= '0;
							hi_q    <= count_q;
							state_q <= S_SRCH_RD;
						end
					endcase
				end
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else if (act_q == ACT_INSERT) begin
						pos_q   <= lo_q;
						src_q   <= count_q;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end else if (can_emit) begin
						ovalid_q <= 1'b1;
						res_q    <= '{ST_MISS, zero_ent, count_q, 1'b1};
						state_q  <= S_IDLE;
					end
				end
				S_SRCH_CMP: begin
					if (mem_rdata.key == new_q.key) begin
						if (can_emit) begin
							ovalid_q <= 1'b1;
							res_q    <= '{(act_q == ACT_INSERT) ? ST_DUP : ST_DONE,
								mem_rdata, count_q, 1'b1};
							state_q  <= S_IDLE;
						end
					end else if ($signed(mem_rdata.key) < $signed(new_q.key)) begin
						lo_q    <= mid_q + CNT_W'(1);
						state_q <= S_SRCH_RD;
					end else begin
						hi_q    <= mid_q;
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT: begin
					// Reads run one entry ahead of the writes, so one entry moves per cycle.
					if (src_q > pos_q) begin
						src_q  <= src_m1;
						wr_q   <= src_q;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (!pend_q && src_q <= pos_q && can_emit) begin
						count_q  <= count_q + CNT_W'(1);
						ovalid_q <= 1'b1;
						res_q    <= '{ST_DONE, new_q, count_q + CNT_W'(1), 1'b1};
						state_q  <= S_IDLE;
					end
				end
				S_SPLIT: begin
					if (can_emit) begin
						ovalid_q <= 1'b1;
						res_q    <= '{ST_SPLIT, mem_rdata, count_q, split_last};
						idx_q    <= idx_nx;
						if (split_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_write_only_shift: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> state_q == S_SHIFT)
		else $error("memory written outside the shift sequence");

	a_move_above_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && pend_q) |-> wr_q > pos_q)
		else $error("shift wrote at or below the insertion point");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.re && mem_req.we) |-> mem_req.raddr != mem_req.waddr)
		else $error("read and write hit the same entry in one cycle");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in work");

endmodule

@@ rtl/sorted_key_table_leaf_top.sv @@
// Top level of the sorted key table leaf: config register, sequencer and entry memory.
//
// The block keeps up to 64 entries (signed 64-bit key, 32-bit page, 32-bit slot) in
// ascending key order in a single-port-write, single-port-read synchronous memory.
// Items arrive on the in_valid/in_ready channel; results leave on out_valid/out_ready.
// One item is worked on at a time: in_ready is high only while the sequencer is idle,
// and it may be high while the last result still sits in the output register.
// Lookup is a binary search in which every step is one memory read followed by one
// compare. Insert runs the search, then moves one entry per cycle through the memory
// ports to open the insertion point, so filling the last free entry at position zero
// moves 63 entries. Split streams the upper half out at one item per cycle while the
// receiver takes them; clear, full and empty cases answer from the dispatch state.
// The last output field marks the final result that an item causes.
// When the receiver stalls, the output register holds its item and the sequencer
// waits at its next result, so nothing is dropped.
// Reset empties the table at once (the count goes to zero; memory contents are never
// cleared) and sets max_entries to 64. cfg_we writes max_entries; the user must
// assert it only while the block idles, as the block itself does not enforce this.
module sorted_key_table_leaf_top
	import skt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic signed [63:0]  search_key,
	input  logic signed [31:0]  entry_page,
	input  logic signed [31:0]  entry_slot,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic signed [63:0]  found_key,
	output logic signed [31:0]  found_page,
	output logic signed [31:0]  found_slot,
	output logic [CNT_W-1:0]    entry_count,
	output logic                last
);

	logic [CNT_W-1:0] max_entries_q;
	mem_req_t         mem_req;
	entry_t           mem_rdata;
	result_t          res;

	// The limit register must be written only while no item is in work (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_RESET;
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	skt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.search_key  (search_key),
		.entry_page  (entry_page),
		.entry_slot  (entry_slot),
		.max_entries (max_entries_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	skt_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign status      = res.status;
	assign found_key   = res.ent.key;
	assign found_page  = res.ent.page;
	assign found_slot  = res.ent.slot;
	assign entry_count = res.count;
	assign last        = res.last;

endmodule
